@@ rtl/core/tsdf_pkg.sv @@
package tsdf_pkg;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_TABS        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

  // Characters used by the formatter
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  // Byte classes for nonprinting escapes
  localparam logic [7:0] CODE_SPACE = 8'd32;
  localparam logic [7:0] CODE_DEL   = 8'd127;
  localparam logic [7:0] CODE_HIGH  = 8'd128;
  localparam logic [7:0] CODE_NBSP  = 8'd160;
  localparam logic [7:0] CODE_MAX   = 8'd255;
  localparam logic [7:0] OFS_CTRL   = 8'd64;
  localparam logic [7:0] OFS_META   = 8'd128;

  localparam logic [3:0] BCD_NINE = 4'd9;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // Line state carried from one byte to the next
  typedef struct packed {
    logic prev_nl;
    logic empty_seen;
  } line_state_t;

endpackage

@@ rtl/core/tsdf_fmt.sv @@
// Formats one input byte: line number, marker and escape bytes, next line state.
module tsdf_fmt #(
  parameter int COUNTER_DIGITS = 6,
  localparam int NB = COUNTER_DIGITS + 5,
  localparam int LW = $clog2(NB + 1),
  localparam int CW = 4 * COUNTER_DIGITS
) (
  input  tsdf_pkg::cfg_t          cfg,
  input  logic [7:0]              in_byte,
  input  logic                    file_start,
  input  tsdf_pkg::line_state_t   st,
  input  logic [CW-1:0]           counter,
  output logic [NB-1:0][7:0]      fbuf,
  output logic [LW-1:0]           flen,
  output tsdf_pkg::line_state_t   st_next,
  output logic [CW-1:0]           counter_next
);

  logic                             is_nl;
  logic                             is_tab;
  logic                             esn;
  logic                             drop;
  logic                             do_num;
  logic                             carry;
  logic                             lead;
  logic [3:0]                       d;
  logic [CW-1:0]                    inc;
  logic [COUNTER_DIGITS:0][7:0]     numtxt;
  logic [2:0][7:0]                  pre;
  logic [1:0]                       plen;
  logic [7:0]                       fc;
  logic [3:0][7:0]                  body;
  logic [2:0]                       blen;
  logic                             prev_next;

  always_comb begin
    is_nl  = (in_byte == tsdf_pkg::CH_NL);
    is_tab = (in_byte == tsdf_pkg::CH_TAB);
    esn    = file_start ? 1'b0 : st.empty_seen;
    drop   = cfg.squeeze_blank && is_nl && esn;
    do_num = st.prev_nl && ((cfg.number_all && !cfg.number_nonblank) ||
                            (cfg.number_nonblank && !is_nl));

    // BCD increment, held at all nines
    carry = 1'b1;
    inc   = counter;
    for (int i = 0; i < COUNTER_DIGITS; i++) begin
      d = counter[4*i +: 4];
      if (carry) inc[4*i +: 4] = (d == tsdf_pkg::BCD_NINE) ? 4'd0 : d + 4'd1;
      carry = carry && (d == tsdf_pkg::BCD_NINE);
    end
    counter_next = (do_num && !drop && !carry) ? inc : counter;

    // Number text, leading zeros blanked except the units digit
    lead = 1'b1;
    for (int i = COUNTER_DIGITS - 1; i >= 0; i--) begin
      d = counter[4*i +: 4];
      if (lead && d == 4'd0 && i != 0) begin
        numtxt[COUNTER_DIGITS-1-i] = tsdf_pkg::CH_SPACE;
      end else begin
        lead = 1'b0;
        numtxt[COUNTER_DIGITS-1-i] = tsdf_pkg::CH_ZERO + {4'd0, d};
      end
    end
    numtxt[COUNTER_DIGITS] = tsdf_pkg::CH_TAB;

    // Prefix bytes and final character
    pre  = '0;
    plen = 2'd0;
    fc   = in_byte;
    if (cfg.show_tabs && is_tab) begin
      pre[0]    = tsdf_pkg::CH_CARET;
      plen      = 2'd1;
      fc        = tsdf_pkg::CH_I;
      prev_next = 1'b0;
    end else begin
      if (cfg.show_ends && is_nl) begin
        pre[0] = tsdf_pkg::CH_DOLLAR;
        plen   = 2'd1;
      end
      if (cfg.show_nonprinting) begin
        if (in_byte == tsdf_pkg::CODE_DEL) begin
          pre[0] = tsdf_pkg::CH_CARET;
          plen   = 2'd1;
          fc     = tsdf_pkg::CH_QMARK;
        end else if (in_byte < tsdf_pkg::CODE_SPACE && !is_tab && !is_nl) begin
          pre[0] = tsdf_pkg::CH_CARET;
          plen   = 2'd1;
          fc     = in_byte + tsdf_pkg::OFS_CTRL;
        end else if (in_byte == tsdf_pkg::CODE_MAX) begin
          pre  = {tsdf_pkg::CH_CARET, tsdf_pkg::CH_DASH, tsdf_pkg::CH_M};
          plen = 2'd3;
          fc   = tsdf_pkg::CH_QMARK;
        end else if (in_byte >= tsdf_pkg::CODE_HIGH && in_byte < tsdf_pkg::CODE_NBSP) begin
          pre  = {tsdf_pkg::CH_CARET, tsdf_pkg::CH_DASH, tsdf_pkg::CH_M};
          plen = 2'd3;
          fc   = in_byte - tsdf_pkg::OFS_CTRL;
        end else if (in_byte >= tsdf_pkg::CODE_NBSP) begin
          pre[1:0] = {tsdf_pkg::CH_DASH, tsdf_pkg::CH_M};
          plen     = 2'd2;
          fc       = in_byte - tsdf_pkg::OFS_META;
        end
      end
      prev_next = (fc == tsdf_pkg::CH_NL);
    end

    // Body = prefix followed by the final character
    for (int i = 0; i < 4; i++) begin
      if (i < 32'(plen))       body[i] = pre[i];
      else if (i == 32'(plen)) body[i] = fc;
      else                     body[i] = 8'd0;
    end
    blen = {1'b0, plen} + 3'd1;

    // Assemble the output run
    fbuf = '0;
    if (do_num) begin
      for (int i = 0; i <= COUNTER_DIGITS; i++) fbuf[i] = numtxt[i];
      for (int i = 0; i < 4; i++) fbuf[COUNTER_DIGITS+1+i] = body[i];
      flen = LW'(COUNTER_DIGITS + 1) + LW'(blen);
    end else begin
      for (int i = 0; i < 4; i++) fbuf[i] = body[i];
      flen = LW'(blen);
    end

    if (drop) begin
      flen               = '0;
      st_next.prev_nl    = 1'b1;
      st_next.empty_seen = 1'b1;
    end else begin
      st_next.prev_nl    = prev_next;
      st_next.empty_seen = is_nl && st.prev_nl;
    end
  end

endmodule

@@ rtl/core/text_stream_display_filter.sv @@
// Channel  | Dir | Fields (low bit up)            | Handshake
// s_*      | in  | tdata: in_byte; tuser: file_start | s_tvalid & s_tready
// m_*      | out | tdata: out_byte; tlast: last_of_run | m_tvalid & m_tready
// cfg_*    | in  | cfg_index, cfg_data (bit 0)    | cfg_we
//
// An accepted byte is formatted into a run of 0 to COUNTER_DIGITS+5 bytes
// held in a shift buffer; the run drains one byte per cycle through the
// output register while the output is not stalled. Input is held off while
// a run drains; a squeezed newline yields nothing.
// Input is taken whenever the buffer is empty or its last byte moves out.
// rst is synchronous: clears config and the run, sets line state to line start and counter to 1.
// Output stalls back up through the buffer; nothing is dropped.
module text_stream_display_filter #(
  parameter int COUNTER_DIGITS = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] in_byte
  input  logic                           s_tuser,   // [0] file_start
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [tsdf_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data
);

  localparam int NB = COUNTER_DIGITS + 5;
  localparam int LW = $clog2(NB + 1);
  localparam int CW = 4 * COUNTER_DIGITS;

  tsdf_pkg::cfg_t        cfg;
  tsdf_pkg::line_state_t st;
  tsdf_pkg::line_state_t st_next;
  logic [CW-1:0]         counter;
  logic [CW-1:0]         counter_next;
  logic [NB-1:0][7:0]    fbuf;
  logic [LW-1:0]         flen;
  logic [NB-1:0][7:0]    run_buf;
  logic [LW-1:0]         run_left;
  logic                  out_load;
  logic                  accept;

  tsdf_fmt #(.COUNTER_DIGITS(COUNTER_DIGITS)) u_fmt (
    .cfg          (cfg),
    .in_byte      (s_tdata),
    .file_start   (s_tuser),
    .st           (st),
    .counter      (counter),
    .fbuf         (fbuf),
    .flen         (flen),
    .st_next      (st_next),
    .counter_next (counter_next)
  );

  // Handshake control
  assign out_load = (run_left != '0) && (!m_tvalid || m_tready);
  assign s_tready = (run_left == '0) || (out_load && run_left == LW'(1));
  assign accept   = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsdf_pkg::REG_NUMBER_ALL:       cfg.number_all       <= cfg_data;
        tsdf_pkg::REG_NUMBER_NONBLANK:  cfg.number_nonblank  <= cfg_data;
        tsdf_pkg::REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= cfg_data;
        tsdf_pkg::REG_SHOW_ENDS:        cfg.show_ends        <= cfg_data;
        tsdf_pkg::REG_SHOW_TABS:        cfg.show_tabs        <= cfg_data;
        tsdf_pkg::REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line state and counter update per input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev_nl    <= 1'b1;
      st.empty_seen <= 1'b0;
      counter       <= CW'(1);
    end else if (accept) begin
      st      <= st_next;
      counter <= counter_next;
    end
  end

  // Run buffer: load on accept, shift on each output load
  always_ff @(posedge clk) begin
    if (rst) begin
      run_left <= '0;
    end else if (accept) begin
      run_left <= flen;
    end else if (out_load) begin
      run_left <= run_left - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run_buf <= fbuf;
    end else if (out_load) begin
      for (int i = 0; i < NB - 1; i++) run_buf[i] <= run_buf[i+1];
      run_buf[NB-1] <= 8'd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= run_buf[0];
      m_tlast <= (run_left == LW'(1));
    end
  end

  // Checks
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_left <= LW'(NB)) else $error("run length out of range");

  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    run_left > LW'(1) |-> !s_tready) else $error("input taken mid run");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_load && run_left == LW'(1) |=> m_tvalid && m_tlast)
    else $error("last byte of run not flagged");

  a_counter_nonzero: assert property (@(posedge clk) disable iff (rst)
    counter != '0) else $error("line counter reached zero");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(counter)) else $error("counter moved without input");

endmodule

@@ sim/tb_text_stream_display_filter.sv @@
`timescale 1ns / 1ps

module tb_text_stream_display_filter;

  localparam int LINE_DIGITS = 6;
  localparam int unsigned LINE_NO_MAX = 999999;
  localparam int PHASE_ITEMS = 36;
  localparam int RAND_PHASES = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 4000;

  // Indexes past the last register; writes there must not change anything
  localparam logic [tsdf_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [tsdf_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // Predicts the formatted byte stream and checks the output against it
  class display_filter_scoreboard;
    tsdf_pkg::cfg_t cfg;
    logic           prev_nl;
    logic           empty_seen;
    int unsigned    line_no;
    out_beat_t      expected_bytes[$];
    int             errors;

    function new();
      cfg = '0;
      prev_nl = 1'b1;
      empty_seen = 1'b0;
      line_no = 1;
      errors = 0;
    endfunction

    function void write_reg(logic [tsdf_pkg::REG_IDX_W-1:0] idx, logic v);
      case (idx)
        tsdf_pkg::REG_NUMBER_ALL:       cfg.number_all = v;
        tsdf_pkg::REG_NUMBER_NONBLANK:  cfg.number_nonblank = v;
        tsdf_pkg::REG_SQUEEZE_BLANK:    cfg.squeeze_blank = v;
        tsdf_pkg::REG_SHOW_ENDS:        cfg.show_ends = v;
        tsdf_pkg::REG_SHOW_TABS:        cfg.show_tabs = v;
        tsdf_pkg::REG_SHOW_NONPRINTING: cfg.show_nonprinting = v;
        default: ;
      endcase
    endfunction

    // Works out the run of bytes one input byte produces
    function void format_byte(logic [7:0] in_byte, logic file_start);
      logic [7:0]  run[$];
      logic [7:0]  c;
      logic [7:0]  digits[LINE_DIGITS];
      logic        is_nl;
      int unsigned v;
      int          i;
      c = in_byte;
      is_nl = (c == tsdf_pkg::CH_NL);
      if (file_start)
        empty_seen = 1'b0;
      // squeezed newline: nothing comes out
      if (cfg.squeeze_blank && is_nl && empty_seen) begin
        prev_nl = 1'b1;
        return;
      end
      empty_seen = is_nl && prev_nl;
      // line number, right-aligned, then a tab
      if (prev_nl && ((cfg.number_all && !cfg.number_nonblank) ||
                      (cfg.number_nonblank && !is_nl))) begin
        v = line_no;
        for (i = LINE_DIGITS - 1; i >= 0; i--) begin
          digits[i] = tsdf_pkg::CH_ZERO + 8'(v % 10);
          v = v / 10;
        end
        for (i = 0; i < LINE_DIGITS - 1 && digits[i] == tsdf_pkg::CH_ZERO; i++)
          digits[i] = tsdf_pkg::CH_SPACE;
        for (i = 0; i < LINE_DIGITS; i++)
          run.push_back(digits[i]);
        run.push_back(tsdf_pkg::CH_TAB);
        if (line_no < LINE_NO_MAX)
          line_no++;
      end
      if (cfg.show_tabs && c == tsdf_pkg::CH_TAB) begin
        run.push_back(tsdf_pkg::CH_CARET);
        run.push_back(tsdf_pkg::CH_I);
        prev_nl = 1'b0;
      end else begin
        if (cfg.show_ends && is_nl)
          run.push_back(tsdf_pkg::CH_DOLLAR);
        if (cfg.show_nonprinting) begin
          if (c == tsdf_pkg::CODE_DEL) begin
            run.push_back(tsdf_pkg::CH_CARET);
            c = tsdf_pkg::CH_QMARK;
          end else if (c < tsdf_pkg::CODE_SPACE && c != tsdf_pkg::CH_TAB &&
                       c != tsdf_pkg::CH_NL) begin
            run.push_back(tsdf_pkg::CH_CARET);
            c = c + tsdf_pkg::OFS_CTRL;
          end else if (c == tsdf_pkg::CODE_MAX) begin
            run.push_back(tsdf_pkg::CH_M);
            run.push_back(tsdf_pkg::CH_DASH);
            run.push_back(tsdf_pkg::CH_CARET);
            c = tsdf_pkg::CH_QMARK;
          end else if (c >= tsdf_pkg::CODE_HIGH && c < tsdf_pkg::CODE_NBSP) begin
            run.push_back(tsdf_pkg::CH_M);
            run.push_back(tsdf_pkg::CH_DASH);
            run.push_back(tsdf_pkg::CH_CARET);
            c = c - tsdf_pkg::OFS_CTRL;
          end else if (c >= tsdf_pkg::CODE_NBSP) begin
            run.push_back(tsdf_pkg::CH_M);
            run.push_back(tsdf_pkg::CH_DASH);
            c = c - tsdf_pkg::OFS_META;
          end
        end
        run.push_back(c);
        prev_nl = (c == tsdf_pkg::CH_NL);
      end
      foreach (run[k])
        expected_bytes.push_back('{data: run[k], last: (k == run.size() - 1)});
    endfunction

    function void check_output(logic [7:0] data, logic last);
      out_beat_t want;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: none expected, got %02h (last_of_run %0b)", data, last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata = '0;   // [7:0] in_byte
  logic                           s_tuser = 1'b0; // [0] file_start
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [7:0]                     m_tdata;        // [7:0] out_byte
  logic                           m_tlast;        // last_of_run
  logic                           cfg_we = 1'b0;
  logic [tsdf_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic                           cfg_data = 1'b0;

  logic calm = 1'b0;
  int   quiet_cycles = 0;

  display_filter_scoreboard sb = new();

  text_stream_display_filter #(
    .COUNTER_DIGITS(LINE_DIGITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random backpressure, none during the calm phase
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 21);
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_output(m_tdata, m_tlast);
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** text_stream_display_filter: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [tsdf_pkg::REG_IDX_W-1:0] idx, input logic v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // Writes every register, plus one write to an unused index
  task automatic apply_settings(input tsdf_pkg::cfg_t s);
    write_reg(tsdf_pkg::REG_NUMBER_ALL, s.number_all);
    write_reg(tsdf_pkg::REG_NUMBER_NONBLANK, s.number_nonblank);
    write_reg(tsdf_pkg::REG_SQUEEZE_BLANK, s.squeeze_blank);
    write_reg(tsdf_pkg::REG_SHOW_ENDS, s.show_ends);
    write_reg(tsdf_pkg::REG_SHOW_TABS, s.show_tabs);
    write_reg(tsdf_pkg::REG_SHOW_NONPRINTING, s.show_nonprinting);
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
              1'($urandom_range(0, 1)));
    cfg_we <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fs);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= fs;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    sb.format_byte(b, fs);
    // idle at random between bytes, about one chance in five, never when calm
    while (!calm && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off input until every expected byte is out and the block is idle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return 8'($urandom_range(8'h20, 8'h7E));
    else if (r < 55)
      return tsdf_pkg::CH_TAB;
    else if (r < 65)
      return 8'($urandom_range(0, 31));
    else if (r < 69)
      return tsdf_pkg::CODE_DEL;
    else if (r < 84)
      return 8'($urandom_range(128, 255));
    else if (r < 88)
      return tsdf_pkg::CH_NL;
    else
      return 8'($urandom_range(0, 255));
  endfunction

  // One text line; empty lines are frequent so squeezing gets exercised
  task automatic send_line(inout int count);
    int   len;
    logic fs;
    len = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 7);
    fs = ($urandom_range(0, 99) < 6);
    for (int i = 0; i < len; i++) begin
      send_byte(pick_char(), fs);
      fs = 1'b0;
      count++;
    end
    send_byte(($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255)) : tsdf_pkg::CH_NL,
              fs);
    count++;
  endtask

  initial begin
    tsdf_pkg::cfg_t s;
    int             sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: plain pass-through at reset settings
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(tsdf_pkg::CH_NL, 1'b0);
    send_byte(tsdf_pkg::CH_TAB, 1'b0);
    drain();

    // Directed: number every line, show ends, tabs and escapes
    s = '0;
    s.number_all = 1'b1;
    s.show_ends = 1'b1;
    s.show_tabs = 1'b1;
    s.show_nonprinting = 1'b1;
    apply_settings(s);
    send_byte(tsdf_pkg::CH_NL, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(tsdf_pkg::CH_TAB, 1'b0);
    send_byte(tsdf_pkg::CODE_DEL, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(tsdf_pkg::CODE_HIGH, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(tsdf_pkg::CODE_NBSP, 1'b0);
    send_byte(tsdf_pkg::CODE_MAX, 1'b0);
    send_byte(tsdf_pkg::CH_NL, 1'b0);
    send_byte(8'h7E, 1'b0);
    drain();

    // Directed: both numbering modes on, squeeze, new file clears the blank flag
    apply_settings('1);
    send_byte(tsdf_pkg::CH_NL, 1'b0);
    send_byte(tsdf_pkg::CH_NL, 1'b0);
    send_byte(tsdf_pkg::CH_NL, 1'b0);
    send_byte(tsdf_pkg::CH_NL, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(tsdf_pkg::CH_NL, 1'b0);
    drain();

    // Directed: escapes alone leave tab and newline as they are
    s = '0;
    s.show_nonprinting = 1'b1;
    apply_settings(s);
    send_byte(tsdf_pkg::CH_TAB, 1'b0);
    send_byte(tsdf_pkg::CH_NL, 1'b0);
    send_byte(8'h1F, 1'b0);
    drain();

    // Random text under a series of settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0)
        s = '0;
      else if (p == 1)
        s = '1;
      else
        s = tsdf_pkg::cfg_t'(6'($urandom_range(0, 63)));
      calm <= (p == 2);
      apply_settings(s);
      sent = 0;
      while (sent < PHASE_ITEMS)
        send_line(sent);
      drain();
    end

    if (sb.errors == 0)
      $display("** text_stream_display_filter: PASSED **");
    else
      $display("** text_stream_display_filter: FAILED **");
    $finish;
  end

endmodule

@@ text_stream_display_filter.f @@
rtl/core/tsdf_pkg.sv
rtl/core/tsdf_fmt.sv
rtl/core/text_stream_display_filter.sv
sim/tb_text_stream_display_filter.sv
